// ----- rtl/spq_pkg.sv -----
// spq_pkg: constants, result codes and cell control type for the sorted priority queue
// no dependencies; imported by spq_cell and sorted_priority_queue_unit
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;
  localparam int OUT_W    = DATA_W + STATUS_W + OCC_W;
  localparam int OUT_PAD  = ((OUT_W + 7) / 8) * 8 - OUT_W;
  localparam int TDATA_W  = OUT_W + OUT_PAD;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [DATA_W-1:0] value;
  } spq_ctl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// spq_cell: one slot of the sorted chain, holds one entry and trades with its neighbours
// depends on spq_pkg
module spq_cell
  import spq_pkg::*;
(
  input  logic              clk,
  input  spq_ctl_t          ctl,
  input  logic              occ,
  input  logic              prev_gt,
  input  logic [DATA_W-1:0] prev_val,
  input  logic [DATA_W-1:0] next_val,
  output logic              gt,
  output logic [DATA_W-1:0] val
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  assign gt  = occ && ($signed(val_r) > $signed(ctl.value));
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.push) begin
      if (!gt) begin
        val_nxt = prev_gt ? ctl.value : prev_val;
      end
    end else if (ctl.pop) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- rtl/sorted_priority_queue_unit.sv -----
// sorted_priority_queue_unit: max-first priority queue as a chain of sorted cells
// depends on spq_pkg and spq_cell
//
// Requests arrive on the in_ stream: in_tuser is the command (push or pop) and
// in_tdata the signed value to push. Every request gives one result on the out_
// stream: popped value, status and occupancy after the request.
// The chain keeps the largest entry in cell 0; a push compares the value with
// every cell at once and each cell keeps, takes the value or takes its left
// neighbour; a pop moves every cell one place toward the head.
// Throughput is one request per cycle while the output is not stalled, set by the
// combinational compare in each cell; the result is registered and appears in the cycle after the request.
// A pop on an empty queue returns -1 with empty status; a push to a full
// queue is dropped with full status.
// The output register lets a new request in while the result is taken in the
// same cycle; while out_tready is low and a result waits, in_tready is low.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result;
// the cell contents are not cleared, the entry count alone marks them.
module sorted_priority_queue_unit
  import spq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [DATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic [0:0]         in_tuser,   // [0] command
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata   // [31:0] popped_value, [33:32] status,
                                         // [40:34] occupancy, rest zero
);

  spq_ctl_t ctl;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   popped_r, popped_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [OCC_W-1:0]    occ_r;

  logic [DATA_W-1:0]   cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_occ;

  logic                acc, is_pop, full, empty;
  logic [CNT_W+OCC_W-1:0] cnt_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign is_pop    = (in_tuser[0] == CMD_POP);
  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign empty     = (cnt_r == '0);

  assign ctl.push  = acc && !is_pop && !full;
  assign ctl.pop   = acc && is_pop && !empty;
  assign ctl.value = in_tdata;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_occ[i] = (CNT_W'(i) < cnt_r);
      if (i == 0) begin : g_head
        spq_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .occ      (cell_occ[i]),
          .prev_gt  (1'b1),
          .prev_val (ctl.value),
          .next_val (cell_val[i+1]),
          .gt       (cell_gt[i]),
          .val      (cell_val[i])
        );
      end else if (i == CAPACITY - 1) begin : g_tail
        spq_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .occ      (cell_occ[i]),
          .prev_gt  (cell_gt[i-1]),
          .prev_val (cell_val[i-1]),
          .next_val (cell_val[i]),
          .gt       (cell_gt[i]),
          .val      (cell_val[i])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .occ      (cell_occ[i]),
          .prev_gt  (cell_gt[i-1]),
          .prev_val (cell_val[i-1]),
          .next_val (cell_val[i+1]),
          .gt       (cell_gt[i]),
          .val      (cell_val[i])
        );
      end
    end
  endgenerate

  always_comb begin
    cnt_nxt    = cnt_r;
    popped_nxt = '0;
    status_nxt = ST_OK;
    if (ctl.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.pop) begin
      cnt_nxt    = cnt_r - CNT_W'(1);
      popped_nxt = cell_val[0];
    end else if (is_pop) begin
      popped_nxt = EMPTY_VALUE;
      status_nxt = ST_EMPTY;
    end else begin
      status_nxt = ST_FULL;
    end
  end

  assign cnt_ext = {{OCC_W{1'b0}}, cnt_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
      occ_r    <= cnt_ext[OCC_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, occ_r, status_r, popped_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_tvalid)
    else $error("accepted request gave no result");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r == ST_EMPTY) |-> (popped_r == EMPTY_VALUE && occ_r == '0))
    else $error("empty pop result malformed");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CNT_W'(2)) |-> ($signed(cell_val[0]) >= $signed(cell_val[1])))
    else $error("head cells out of order");

endmodule

// ----- tb/spq_pop_order_check.sv -----
// spq_pop_order_check: watches both streams of the sorted priority queue, predicts
// each result from its own sorted copy of the queue and compares field by field
// depends on spq_pkg; instantiated beside the block by tb_sorted_priority_queue_unit
module spq_pop_order_check
  import spq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [DATA_W-1:0]  in_tdata,
  input  logic [0:0]         in_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDATA_W-1:0] out_tdata,
  output int                 error_count,
  output int                 pending,
  output int                 push_count,
  output int                 pop_count,
  output int                 empty_count,
  output int                 full_count
);

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } pop_result_t;

  // largest first, newest of equal values ahead of older ones
  logic signed [DATA_W-1:0] held_values[$];
  pop_result_t              awaited_results[$];

  function automatic pop_result_t apply_request(input logic cmd,
                                                input logic signed [DATA_W-1:0] val);
    pop_result_t r;
    int pos;
    r.value  = '0;
    r.status = ST_OK;
    if (cmd == CMD_PUSH) begin
      if (held_values.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_values.size() && held_values[pos] > val) pos++;
        held_values.insert(pos, val);
      end
    end else if (held_values.size() == 0) begin
      r.value  = EMPTY_VALUE;
      r.status = ST_EMPTY;
    end else begin
      r.value = held_values.pop_front();
    end
    r.occupancy = OCC_W'(held_values.size());
    return r;
  endfunction

  task automatic check_field(input string field, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      error_count++;
      $display("%0t: %s expected %0d got %0d", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    pop_result_t want;
    pop_result_t got;
    if (!rst_n) begin
      held_values.delete();
      awaited_results.delete();
      error_count = 0;
      push_count  = 0;
      pop_count   = 0;
      empty_count = 0;
      full_count  = 0;
    end else begin
      // the result is registered, so a result never belongs to this edge's request
      if (out_tvalid && out_tready) begin
        got.value     = out_tdata[DATA_W-1:0];
        got.status    = out_tdata[DATA_W +: STATUS_W];
        got.occupancy = out_tdata[DATA_W+STATUS_W +: OCC_W];
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t: result expected none got value %0d status %0d occupancy %0d",
                   $time, $signed(got.value), got.status, got.occupancy);
        end else begin
          want = awaited_results.pop_front();
          check_field("popped value", $signed(want.value), $signed(got.value));
          check_field("status", want.status, got.status);
          check_field("occupancy", want.occupancy, got.occupancy);
          check_field("padding", 0, out_tdata >> OUT_W);
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_request(in_tuser[0], in_tdata);
        awaited_results.push_back(want);
        if (in_tuser[0] == CMD_PUSH) push_count++;
        else pop_count++;
        if (want.status == ST_EMPTY) empty_count++;
        if (want.status == ST_FULL) full_count++;
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ----- tb/tb_sorted_priority_queue_unit.sv -----
// tb_sorted_priority_queue_unit: stimulus, stall patterns and verdict for the queue
// depends on spq_pkg, sorted_priority_queue_unit and spq_pop_order_check
module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  localparam int ITEMS       = 1300;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [DATA_W-1:0]  in_tdata;
  logic [0:0]         in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;

  int error_count, pending, push_count, pop_count, empty_count, full_count;
  int send_idle_pct;
  int recv_idle_pct;
  int sent;
  int level;
  int burst_len;
  int stall_cycles;

  sorted_priority_queue_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  spq_pop_order_check order_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .error_count (error_count),
    .pending     (pending),
    .push_count  (push_count),
    .pop_count   (pop_count),
    .empty_count (empty_count),
    .full_count  (full_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] pick_value();
    int near_zero;
    near_zero = $urandom_range(0, 8);
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: return DATA_W'(near_zero - 4);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_request(input logic cmd, input logic [DATA_W-1:0] val);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    sent++;
    if (cmd == CMD_PUSH) begin
      if (level < CAPACITY) level++;
    end else if (level > 0) begin
      level--;
    end
  endtask

  // receiver side, one long hold-off once the last third of the run starts
  initial begin
    bit held_off;
    held_off = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && sent >= 2 * ITEMS / 3) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb_sorted_priority_queue_unit: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= CMD_PUSH;
    send_idle_pct = 17;
    recv_idle_pct = 53;
    sent          = 0;
    level         = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // pops on empty, extremes, equal values, then drain past empty
    send_request(CMD_POP, '0);
    send_request(CMD_POP, '1);
    send_request(CMD_PUSH, 32'h0000_0000);
    send_request(CMD_PUSH, 32'h7FFF_FFFF);
    send_request(CMD_PUSH, 32'h8000_0000);
    send_request(CMD_PUSH, 32'hFFFF_FFFF);
    send_request(CMD_PUSH, 32'hFFFF_FFFF);
    send_request(CMD_PUSH, 32'h0000_0001);
    send_request(CMD_PUSH, 32'h8000_0001);
    send_request(CMD_PUSH, 32'h7FFF_FFFE);
    repeat (9) send_request(CMD_POP, $urandom());
    send_request(CMD_PUSH, 32'h5555_AAAA);
    send_request(CMD_POP, 32'hAAAA_5555);

    while (sent < ITEMS) begin
      if (sent < ITEMS / 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 53;
      end else if (sent < 2 * ITEMS / 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // fill to capacity and push past it
          burst_len = CAPACITY - level + $urandom_range(1, 3);
          repeat (burst_len) send_request(CMD_PUSH, pick_value());
        end
        3, 4: begin
          // drain to empty and pop past it
          burst_len = level + $urandom_range(1, 2);
          repeat (burst_len) send_request(CMD_POP, $urandom());
        end
        default: begin
          repeat (24) send_request(logic'($urandom_range(0, 1)), pick_value());
        end
      endcase
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests: %0d pushes, %0d pops, %0d pops on empty, %0d pushes on full",
             push_count + pop_count, push_count, pop_count, empty_count, full_count);
    $display("sender and receiver stalls in three mixes plus one long receiver hold-off");
    if (error_count == 0) begin
      $display("tb_sorted_priority_queue_unit: done, clean");
    end else begin
      $display("tb_sorted_priority_queue_unit: done, errors");
    end
    $finish;
  end

endmodule
